// ===== design/well512_random_generator_unit_macros.svh =====
// Assertion macros shared by the generator RTL
`ifndef WELL512_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define WELL512_RANDOM_GENERATOR_UNIT_MACROS_SVH

// check consequent in the same cycle
`define WRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check consequent in the next cycle
`define WRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wrg_pkg.sv =====
// Shared types and constants of the WELL512 generator
`timescale 1ns / 1ps

package wrg_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);
  localparam int WORD_W     = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SEED_RESET  = 32'd1;
  localparam word_t TEMPER_MASK = 32'hDA44_2D24;
  localparam addr_t OFF_FAR     = ADDR_W'(13);
  localparam addr_t OFF_MID     = ADDR_W'(9);
  localparam addr_t OFF_PREV    = ADDR_W'(15);

  typedef struct packed {
    logic  en;
    addr_t pos;
  } rd_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

  typedef struct packed {
    logic busy;
    logic fire;
  } core_stat_t;

endpackage

// ===== design/wrg_pool.sv =====
// State word pool: two replicated memories with reseed valid bits
`timescale 1ns / 1ps

module wrg_pool (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  wrg_pkg::word_t  seed,
  input  wrg_pkg::rd_req_t rd,
  input  wrg_pkg::wr_req_t wr,
  output wrg_pkg::word_t  far_word,
  output wrg_pkg::word_t  mid_word,
  output wrg_pkg::word_t  prev_word
);
  import wrg_pkg::*;

  word_t mem_a [POOL_DEPTH];
  word_t mem_b [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] valid;

  addr_t addr_far;
  addr_t addr_mid;
  addr_t addr_prev;

  word_t q_far, q_mid, q_prev;
  word_t dflt_far, dflt_mid, dflt_prev;
  logic  v_far, v_mid, v_prev;

  assign addr_far  = rd.pos + OFF_FAR;
  assign addr_mid  = rd.pos + OFF_MID;
  assign addr_prev = rd.pos + OFF_PREV;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr] <= wr.data;
      mem_b[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_far     <= mem_a[addr_far];
      q_mid     <= mem_a[addr_mid];
      q_prev    <= mem_b[addr_prev];
      v_far     <= valid[addr_far];
      v_mid     <= valid[addr_mid];
      v_prev    <= valid[addr_prev];
      dflt_far  <= seed * {{(WORD_W-ADDR_W){1'b0}}, addr_far};
      dflt_mid  <= seed * {{(WORD_W-ADDR_W){1'b0}}, addr_mid};
      dflt_prev <= seed * {{(WORD_W-ADDR_W){1'b0}}, addr_prev};
    end
  end

  assign far_word  = v_far  ? q_far  : dflt_far;
  assign mid_word  = v_mid  ? q_mid  : dflt_mid;
  assign prev_word = v_prev ? q_prev : dflt_prev;

endmodule

// ===== design/wrg_core.sv =====
// Recurrence stage, current-word register and output register
`timescale 1ns / 1ps

module wrg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  wrg_pkg::rd_req_t  rd,
  input  wrg_pkg::word_t    far_word,
  input  wrg_pkg::word_t    mid_word,
  input  wrg_pkg::word_t    prev_word,
  output wrg_pkg::wr_req_t  wr,
  output wrg_pkg::core_stat_t stat,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wrg_pkg::word_t    out_word
);
  import wrg_pkg::*;

  logic  s1_valid;
  addr_t s1_pos;
  word_t cur;
  logic  fire;

  word_t b, c, a_new, d, w;

  always_comb begin
    b     = cur ^ far_word ^ (cur << 16) ^ (far_word << 15);
    c     = mid_word ^ (mid_word >> 11);
    a_new = b ^ c;
    d     = a_new ^ ((a_new << 5) & TEMPER_MASK);
    w     = prev_word ^ b ^ d ^ (prev_word << 2) ^ (b << 18) ^ (c << 28);
  end

  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  assign wr.en    = fire;
  assign wr.addr  = s1_pos;
  assign wr.data  = a_new;

  assign stat.busy = s1_valid;
  assign stat.fire = fire;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid <= 1'b0;
    end else if (rd.en) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      s1_pos <= rd.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cur <= '0;
    end else if (fire) begin
      cur <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= w;
    end
  end

endmodule

// ===== design/well512_random_generator_unit.sv =====
// Top level of the WELL512 pseudo-random word generator
//
//   channel   | dir | content
//   s_axis    | in  | tdata[7:0]: bit 0 draw, bits 7:1 zero
//   m_axis    | out | tdata[31:0]: random_word
//   seed_we   | in  | seed register write, data on seed_wdata
//
// One word per cycle while m_axis_tready is high; a request passes the pool read and output registers.
// Pool reads three words a cycle from two replicated memories; one write per cycle.
// Reset and seed writes take effect at once: words not yet rewritten read seed * index.
// With m_axis_tready low, one more request is held in the compute stage, then
// s_axis_tready drops.
`timescale 1ns / 1ps

module well512_random_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] draw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] random_word
  input  logic        seed_we,
  input  logic [31:0] seed_wdata
);
  import wrg_pkg::*;
  `include "well512_random_generator_unit_macros.svh"

  word_t      seed;
  addr_t      position;
  logic       draw_go;
  rd_req_t    rd;
  wr_req_t    wr;
  core_stat_t stat;
  word_t      far_word, mid_word, prev_word;

  assign draw_go = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
  assign rd.en   = draw_go;
  assign rd.pos  = position;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || seed_we) begin
      position <= '0;
    end else if (draw_go) begin
      position <= position - ADDR_W'(1);
    end
  end

  wrg_pool u_pool (
    .clk       (clk),
    .rst       (rst),
    .clear     (seed_we),
    .seed      (seed),
    .rd        (rd),
    .wr        (wr),
    .far_word  (far_word),
    .mid_word  (mid_word),
    .prev_word (prev_word)
  );

  wrg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .clear     (seed_we),
    .rd        (rd),
    .far_word  (far_word),
    .mid_word  (mid_word),
    .prev_word (prev_word),
    .wr        (wr),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata)
  );

  `WRG_ASSERT_NEXT(a_pos_step, draw_go && !seed_we, position == ($past(position) - ADDR_W'(1)), "position did not step back")
  `WRG_ASSERT_NOW(a_no_rw_clash, wr.en && rd.en, (wr.addr != (rd.pos + OFF_FAR)) && (wr.addr != (rd.pos + OFF_MID)) && (wr.addr != (rd.pos + OFF_PREV)), "read hits word being written")
  `WRG_ASSERT_NOW(a_stall_busy, !s_axis_tready, stat.busy, "ready low with empty stage")
  `WRG_ASSERT_NEXT(a_fire_out, stat.fire && !seed_we, m_axis_tvalid, "result not presented")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the WELL512 generator: stream driver, monitor, word predictor
`timescale 1ns / 1ps

module testbench;
  import wrg_pkg::*;

  localparam int  HALF_PERIOD  = 10;
  localparam int  RESET_CYCLES = 3;
  localparam int  SETTLE       = 8;
  localparam int  LIMIT_CYCLES = 400000;
  localparam int  HOLD_AT      = 1200;
  localparam int  RAND_PHASES  = 7;
  localparam int  RAND_ITEMS   = 275;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [0] draw, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] random_word
  logic        seed_we = 1'b0;
  logic [31:0] seed_wdata = 32'd0;

  well512_random_generator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  word_t pool_model [POOL_DEPTH];
  addr_t pos_model;
  word_t word_expect_q[$];
  bit    draw_pending[$];
  int    draws_queued = 0;
  int    requests_taken = 0;
  int    error_count = 0;
  int    cycle_count = 0;
  logic  req_taken = 1'b0;

  function automatic void reseed_pool(word_t seed);
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_model[i] = seed * word_t'(i);
    end
    pos_model = '0;
  endfunction

  function automatic word_t well512_next();
    addr_t p, p_far, p_mid;
    word_t a, b, c, d, w;
    p     = pos_model;
    p_far = p + OFF_FAR;
    p_mid = p + OFF_MID;
    a = pool_model[p];
    c = pool_model[p_far];
    b = a ^ c ^ (a << 16) ^ (c << 15);
    c = pool_model[p_mid];
    c = c ^ (c >> 11);
    a = b ^ c;
    pool_model[p] = a;
    d = a ^ ((a << 5) & TEMPER_MASK);
    p = p + OFF_PREV;
    pos_model = p;
    a = pool_model[p];
    w = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
    pool_model[p] = w;
    return w;
  endfunction

  // predict on accepted draw requests, check accepted words
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      reseed_pool(SEED_RESET);
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (seed_we) begin
        reseed_pool(seed_wdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        requests_taken++;
        if (s_axis_tdata[0]) begin
          word_expect_q.push_back(well512_next());
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (word_expect_q.size() == 0) begin
          $display("%0t: unexpected random_word expected none actual %08h",
                   $time, m_axis_tdata);
          error_count++;
        end else begin
          word_t want;
          want = word_expect_q.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: random_word mismatch expected %08h actual %08h",
                     $time, want, m_axis_tdata);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("well512_random_generator_unit regression: fail");
      $finish;
    end
  end

  // request driver: bursts of random length, random gaps
  int   burst_left = 0;
  int   gap_left = 0;
  logic next_valid;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
    end else if (!(s_axis_tvalid && !req_taken)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (draw_pending.size() > 0) begin
        next_valid = 1'b1;
        s_axis_tdata <= {7'd0, draw_pending.pop_front()};
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // word receiver: changing stall modes plus long hold-offs
  int   rx_cycles = 0;
  int   rx_mode = 0;
  int   mode_left = 0;
  int   hold_left = 0;
  bit   long_hold_done = 1'b0;
  logic next_ready;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 512);
      end else begin
        mode_left--;
      end
      if (hold_left == 0 && !long_hold_done && rx_cycles >= HOLD_AT && s_axis_tvalid) begin
        long_hold_done = 1'b1;
        hold_left      = $urandom_range(200, 400);
      end else if (hold_left == 0 && $urandom_range(0, 1999) == 0) begin
        hold_left = $urandom_range(200, 400);
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            next_ready = 1'b1;
          end
          1: begin
            next_ready = ($urandom_range(0, 1) == 1);
          end
          2: begin
            next_ready = ($urandom_range(0, 3) != 0);
          end
          default: begin
            next_ready = (rx_cycles % 3 != 0);
          end
        endcase
      end
      m_axis_tready <= next_ready;
    end
  end

  task automatic queue_draw(bit draw);
    draw_pending.push_back(draw);
    draws_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (requests_taken != draws_queued || word_expect_q.size() != 0);
  endtask

  task automatic write_seed(word_t seed);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= seed;
    @(negedge clk);
    seed_we <= 1'b0;
    @(posedge clk);
  endtask

  word_t seed_list [RAND_PHASES];

  initial begin
    seed_list[0] = 32'hFFFF_FFFF;
    seed_list[1] = 32'h8000_0000;
    seed_list[2] = $urandom;
    seed_list[3] = 32'd1;
    seed_list[4] = $urandom;
    seed_list[5] = 32'h7FFF_FFFF;
    seed_list[6] = $urandom;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset seed: idle request first, then wrap the position past zero
    queue_draw(1'b0);
    queue_draw(1'b1);
    queue_draw(1'b1);
    queue_draw(1'b0);
    for (int i = 0; i < 16; i++) begin
      queue_draw(1'b1);
    end

    // zero seed: every word stays zero
    write_seed(32'd0);
    for (int i = 0; i < 4; i++) begin
      queue_draw(1'b1);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_seed(seed_list[ph]);
      for (int i = 0; i < RAND_ITEMS; i++) begin
        queue_draw($urandom_range(0, 9) < 8);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && word_expect_q.size() == 0) begin
      $display("well512_random_generator_unit regression: pass");
    end else begin
      $display("well512_random_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/wrg_pkg.sv
design/wrg_pool.sv
design/wrg_core.sv
design/well512_random_generator_unit.sv
dv/testbench.sv
